/* rtl/core/cwl_pkg.sv */
package cwl_pkg;

  typedef enum logic [1:0] {
    MODE_SEND    = 2'd0,
    MODE_RECV    = 2'd1,
    MODE_BYTE    = 2'd2,
    MODE_TIMEOUT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_BYTE    = 3'd0,
    KIND_WORD    = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_DATAERR = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_REPLY = 5'b00010,
    PH_HI    = 5'b00100,
    PH_LO    = 5'b01000,
    PH_SUM   = 5'b10000
  } phase_t;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_ACK   = 2'd0,
    REG_NAK   = 2'd1,
    REG_LIMIT = 2'd2
  } reg_idx_t;

  localparam logic [7:0] ACK_RESET   = 8'd6;
  localparam logic [7:0] NAK_RESET   = 8'd21;
  localparam logic [7:0] LIMIT_RESET = 8'd3;
  localparam logic [15:0] LOW_MASK   = 16'h00ff;

  typedef struct packed {
    logic [7:0] ack_value;
    logic [7:0] nak_value;
    logic [7:0] attempt_limit;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic [15:0] rx_word;
  } res_t;

  // Up to three results caused by one input transfer
  typedef struct packed {
    logic [1:0]     count;
    res_t [2:0]     res;
  } bundle_t;

  function automatic res_t mk_res(kind_t k, logic [7:0] t, logic [15:0] w);
    res_t r;
    r.kind    = k;
    r.tx_byte = t;
    r.rx_word = w;
    return r;
  endfunction

  function automatic logic [7:0] frame_sum(logic [15:0] w);
    logic [15:0] lo;
    lo = w & LOW_MASK;
    return lo[7:0] + w[15:8];
  endfunction

endpackage

/* rtl/core/checksummed_word_link_ack_retry_core.sv */
// Stop-and-wait word link engine with an 8-bit additive checksum.
// Input channel (in_valid/in_stall): one transfer carries a command or a link
//   event: mode selects start send, start receive, byte from link or link
//   timeout; send_word and link_byte carry the payload.
// Output channel (out_valid/out_stall): one transfer per result; kind tells
//   a byte to the link, a received word, send done, timeout or data error.
//   last marks the final result caused by one input transfer.
// Configuration: cfg_we/cfg_index/cfg_data write ack_value, nak_value and
//   attempt_limit; write only while the link is quiet.
// The first result of an input shows on the output in the cycle after its
//   transfer when the queue is empty, later when it waits behind queued
//   results. Throughput: one input per cycle while in_stall is low;
//   results drain at one per cycle while out_stall is low, through a
//   two-entry queue of result bundles (up to three results per input).
// in_stall rises only when both queue entries hold undelivered results.
// A stalled receiver holds the current result steady; inputs keep flowing
//   until the queue fills.
// Reset (rst, synchronous): link goes idle, queue empties, registers return
//   to ack 6, nak 21, attempt limit 3.
module checksummed_word_link_ack_retry_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     mode,
  input  logic [15:0]    send_word,
  input  logic [7:0]     link_byte,
  output logic           out_valid,
  input  logic           out_stall,
  output cwl_pkg::kind_t kind,
  output logic [7:0]     tx_byte,
  output logic [15:0]    rx_word,
  output logic           last,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_data
);
  import cwl_pkg::*;

  cfg_t    cfg;
  bundle_t bnd;
  logic    fire, push, full;

  // Hold the link registers; a write to an unused index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_value     <= ACK_RESET;
      cfg.nak_value     <= NAK_RESET;
      cfg.attempt_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ACK:   cfg.ack_value     <= cfg_data;
        REG_NAK:   cfg.nak_value     <= cfg_data;
        REG_LIMIT: cfg.attempt_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign fire     = in_valid && !in_stall;
  // Inputs that cause no result leave the queue alone
  assign push     = fire && (bnd.count != 2'd0);

  cwl_step u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .mode      (mode),
    .send_word (send_word),
    .link_byte (link_byte),
    .cfg       (cfg),
    .bnd       (bnd)
  );

  cwl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .bnd       (bnd),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .tx_byte   (tx_byte),
    .rx_word   (rx_word),
    .last      (last)
  );

endmodule

/* rtl/core/cwl_step.sv */
module cwl_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [1:0]       mode,
  input  logic [15:0]      send_word,
  input  logic [7:0]       link_byte,
  input  cwl_pkg::cfg_t    cfg,
  output cwl_pkg::bundle_t bnd
);
  import cwl_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] held_word, held_word_next;
  logic [7:0]  attempt_count, attempt_count_next;

  logic [7:0] da, dn, lim, cnt_inc;
  logic       fail_hit;

  always_comb begin
    da       = (link_byte > cfg.ack_value) ? link_byte - cfg.ack_value
                                           : cfg.ack_value - link_byte;
    dn       = (link_byte > cfg.nak_value) ? link_byte - cfg.nak_value
                                           : cfg.nak_value - link_byte;
    lim      = (cfg.attempt_limit == 8'd0) ? 8'd1 : cfg.attempt_limit;
    cnt_inc  = attempt_count + 8'd1;
    fail_hit = cnt_inc >= lim;
  end

  always_comb begin
    phase_next         = phase;
    held_word_next     = held_word;
    attempt_count_next = attempt_count;
    bnd                = '0;
    case (mode_t'(mode))
      MODE_TIMEOUT: begin
        if (phase != PH_IDLE) begin
          phase_next = PH_IDLE;
          bnd.count  = 2'd1;
          bnd.res[0] = mk_res(KIND_TIMEOUT, 8'd0, 16'd0);
        end
      end
      MODE_SEND: begin
        if (phase == PH_IDLE) begin
          attempt_count_next = 8'd0;
          held_word_next     = send_word;
          phase_next         = PH_REPLY;
          bnd.count  = 2'd3;
          bnd.res[0] = mk_res(KIND_BYTE, send_word[15:8], 16'd0);
          bnd.res[1] = mk_res(KIND_BYTE, send_word[7:0], 16'd0);
          bnd.res[2] = mk_res(KIND_BYTE, frame_sum(send_word), 16'd0);
        end
      end
      MODE_RECV: begin
        if (phase == PH_IDLE) begin
          attempt_count_next = 8'd0;
          held_word_next     = 16'd0;
          phase_next         = PH_HI;
        end
      end
      MODE_BYTE: begin
        case (phase)
          PH_IDLE: ; // stray byte, drop
          PH_REPLY: begin
            if (da < dn) begin
              phase_next = PH_IDLE;
              bnd.count  = 2'd1;
              bnd.res[0] = mk_res(KIND_DONE, 8'd0, 16'd0);
            end else begin
              attempt_count_next = cnt_inc;
              if (fail_hit) begin
                phase_next = PH_IDLE;
                bnd.count  = 2'd1;
                bnd.res[0] = mk_res(KIND_DATAERR, 8'd0, 16'd0);
              end else begin
                bnd.count  = 2'd3;
                bnd.res[0] = mk_res(KIND_BYTE, held_word[15:8], 16'd0);
                bnd.res[1] = mk_res(KIND_BYTE, held_word[7:0], 16'd0);
                bnd.res[2] = mk_res(KIND_BYTE, frame_sum(held_word), 16'd0);
              end
            end
          end
          PH_HI: begin
            held_word_next = {link_byte, 8'd0};
            phase_next     = PH_LO;
          end
          PH_LO: begin
            held_word_next = {held_word[15:8], link_byte};
            phase_next     = PH_SUM;
          end
          PH_SUM: begin
            if (frame_sum(held_word) == link_byte) begin
              phase_next = PH_IDLE;
              bnd.count  = 2'd2;
              bnd.res[0] = mk_res(KIND_BYTE, cfg.ack_value, 16'd0);
              bnd.res[1] = mk_res(KIND_WORD, 8'd0, held_word);
            end else begin
              attempt_count_next = cnt_inc;
              bnd.res[0] = mk_res(KIND_BYTE, cfg.nak_value, 16'd0);
              if (fail_hit) begin
                phase_next = PH_IDLE;
                bnd.count  = 2'd2;
                bnd.res[1] = mk_res(KIND_DATAERR, 8'd0, 16'd0);
              end else begin
                phase_next = PH_HI;
                bnd.count  = 2'd1;
              end
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      held_word     <= 16'd0;
      attempt_count <= 8'd0;
    end else if (fire) begin
      phase         <= phase_next;
      held_word     <= held_word_next;
      attempt_count <= attempt_count_next;
    end
  end

endmodule

/* rtl/core/cwl_outq.sv */
module cwl_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cwl_pkg::bundle_t bnd,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output cwl_pkg::kind_t   kind,
  output logic [7:0]       tx_byte,
  output logic [15:0]      rx_word,
  output logic             last
);
  import cwl_pkg::*;

  bundle_t    q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic [1:0] sub;
  bundle_t    head;
  res_t       cur;
  logic       pop;

  always_comb begin
    head      = q[rd_ptr];
    cur       = head.res[sub];
    out_valid = fill != 2'd0;
    full      = fill == 2'd2;
    kind      = cur.kind;
    tx_byte   = cur.tx_byte;
    rx_word   = cur.rx_word;
    last      = sub == (head.count - 2'd1);
    pop       = out_valid && !out_stall && last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= bnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
      sub    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      // advance within the bundle, rewind on its final result
      if (out_valid && !out_stall) begin
        sub <= last ? 2'd0 : sub + 2'd1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/core/cwl_chk.sv */
module cwl_chk (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic [1:0]     mode,
  input logic [15:0]    send_word,
  input logic [7:0]     link_byte,
  input logic           out_valid,
  input logic           out_stall,
  input cwl_pkg::kind_t kind,
  input logic [7:0]     tx_byte,
  input logic [15:0]    rx_word,
  input logic           last,
  input logic           cfg_we,
  input logic [1:0]     cfg_index,
  input logic [7:0]     cfg_data
);
  import cwl_pkg::*;

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(tx_byte)
      && $stable(rx_word) && $stable(last))
    else $error("stalled result changed");

  // Anything but a link byte ends the results of its input
  a_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_BYTE |-> last && tx_byte == 8'd0)
    else $error("status result not final or carries a byte");

  // Only a received word carries word bits
  a_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_WORD |-> rx_word == 16'd0)
    else $error("word bits on a non-word result");

endmodule

bind checksummed_word_link_ack_retry_core cwl_chk u_chk (.*);

/* tb/cwl_link_checker.sv */
module cwl_link_checker
  import cwl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] send_word,
  input  logic [7:0]  link_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  kind_t       kind,
  input  logic [7:0]  tx_byte,
  input  logic [15:0] rx_word,
  input  logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic [15:0] rx_word;
    logic        last;
  } link_out_t;

  link_out_t   due_q[$];
  cfg_t        regs;
  phase_t      link_phase;
  logic [15:0] held_word;
  logic [7:0]  failed_tries;

  function automatic logic [7:0] word_sum(logic [15:0] w);
    return w[15:8] + w[7:0];
  endfunction

  function automatic logic [7:0] byte_distance(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic queue_result(kind_t k, logic [7:0] t, logic [15:0] w);
    link_out_t r;
    r.kind    = k;
    r.tx_byte = t;
    r.rx_word = w;
    r.last    = 1'b0;
    due_q.push_back(r);
  endtask

  task automatic queue_frame();
    queue_result(KIND_BYTE, held_word[15:8], 16'd0);
    queue_result(KIND_BYTE, held_word[7:0], 16'd0);
    queue_result(KIND_BYTE, word_sum(held_word), 16'd0);
  endtask

  // A zero limit behaves as one attempt
  task automatic count_failure(output bit at_limit);
    logic [7:0] lim;
    lim = (regs.attempt_limit == 8'd0) ? 8'd1 : regs.attempt_limit;
    failed_tries = failed_tries + 8'd1;
    at_limit = (failed_tries >= lim);
  endtask

  task automatic step_link(logic [1:0] m, logic [15:0] w, logic [7:0] b);
    int  first;
    bit  at_limit;
    first = due_q.size();
    if (m == MODE_TIMEOUT) begin
      if (link_phase != PH_IDLE) begin
        link_phase = PH_IDLE;
        queue_result(KIND_TIMEOUT, 8'd0, 16'd0);
      end
    end else if (m == MODE_SEND || m == MODE_RECV) begin
      if (link_phase == PH_IDLE) begin
        failed_tries = 8'd0;
        if (m == MODE_SEND) begin
          held_word  = w;
          link_phase = PH_REPLY;
          queue_frame();
        end else begin
          held_word  = 16'd0;
          link_phase = PH_HI;
        end
      end
    end else begin
      case (link_phase)
        PH_REPLY: begin
          if (byte_distance(b, regs.ack_value) < byte_distance(b, regs.nak_value)) begin
            link_phase = PH_IDLE;
            queue_result(KIND_DONE, 8'd0, 16'd0);
          end else begin
            count_failure(at_limit);
            if (at_limit) begin
              link_phase = PH_IDLE;
              queue_result(KIND_DATAERR, 8'd0, 16'd0);
            end else begin
              queue_frame();
            end
          end
        end
        PH_HI: begin
          held_word  = {b, 8'd0};
          link_phase = PH_LO;
        end
        PH_LO: begin
          held_word  = {held_word[15:8], b};
          link_phase = PH_SUM;
        end
        PH_SUM: begin
          if (word_sum(held_word) == b) begin
            link_phase = PH_IDLE;
            queue_result(KIND_BYTE, regs.ack_value, 16'd0);
            queue_result(KIND_WORD, 8'd0, held_word);
          end else begin
            queue_result(KIND_BYTE, regs.nak_value, 16'd0);
            count_failure(at_limit);
            if (at_limit) begin
              link_phase = PH_IDLE;
              queue_result(KIND_DATAERR, 8'd0, 16'd0);
            end else begin
              link_phase = PH_HI;
            end
          end
        end
        default: link_phase = PH_IDLE;
      endcase
    end
    if (due_q.size() > first) due_q[due_q.size() - 1].last = 1'b1;
  endtask

  task automatic note_mismatch(string field, logic [15:0] want, logic [15:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    link_out_t want;
    if (rst) begin
      regs.ack_value     = ACK_RESET;
      regs.nak_value     = NAK_RESET;
      regs.attempt_limit = LIMIT_RESET;
      link_phase   = PH_IDLE;
      held_word    = 16'd0;
      failed_tries = 8'd0;
      due_q.delete();
    end else begin
      // Compare first: a result never belongs to an input taken at the same edge
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual kind %0d byte %0d word %0d",
                   $time, kind, tx_byte, rx_word);
        end else begin
          want = due_q.pop_front();
          if (want.kind !== kind) note_mismatch("kind", 16'(want.kind), 16'(kind));
          if (want.tx_byte !== tx_byte) note_mismatch("tx_byte", 16'(want.tx_byte), 16'(tx_byte));
          if (want.rx_word !== rx_word) note_mismatch("rx_word", want.rx_word, rx_word);
          if (want.last !== last) note_mismatch("last", 16'(want.last), 16'(last));
        end
      end
      // An input taken at the same edge as a register write sees the old value
      if (in_valid && !in_stall) step_link(mode, send_word, link_byte);
      if (cfg_we) begin
        case (cfg_index)
          REG_ACK:   regs.ack_value     = cfg_data;
          REG_NAK:   regs.nak_value     = cfg_data;
          REG_LIMIT: regs.attempt_limit = cfg_data;
          default: ;
        endcase
      end
    end
    pending = due_q.size();
  end

endmodule

/* tb/checksummed_word_link_ack_retry_core_test.sv */
// Stimulus and verdict for the word link core. Prediction and comparison
// live in cwl_link_checker, which watches both channels and the register
// port beside the block and reports its failure count back here.
module checksummed_word_link_ack_retry_core_test;
  import cwl_pkg::*;

  // Cycles with no transfer on either channel before the run is given up
  localparam int STALL_LIMIT = 2000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  mode      = MODE_SEND;
  logic [15:0] send_word = 16'd0;
  logic [7:0]  link_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kind_t       kind;
  logic [7:0]  tx_byte;
  logic [15:0] rx_word;
  logic        last;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = REG_ACK;
  logic [7:0]  cfg_data  = 8'd0;

  int errors;
  int pending;

  // Idling control: calm turns off all idling for the closing stretch
  bit calm          = 1'b0;
  int in_gap_rate   = 0;
  int out_stall_rate = 0;

  // Register values as last written, used to aim reply bytes
  logic [7:0] ack_set   = ACK_RESET;
  logic [7:0] nak_set   = NAK_RESET;
  int         sent_items = 0;
  int         quiet_cycles = 0;

  always #5 clk = ~clk;

  checksummed_word_link_ack_retry_core i_dut (.*);

  cwl_link_checker i_checker (.*);

  // Receiver side: random stall bursts, one drive per falling edge
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) < out_stall_rate) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: restart the count on any transfer, give up after a long silence
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Present one item and hold it until the transfer happens. Returns at the
  // falling edge after the transfer with valid still high, so the caller
  // either presents the next item or drops valid at that same edge.
  task automatic link_event(input logic [1:0] m, input logic [15:0] w, input logic [7:0] b);
    if (!calm && $urandom_range(0, 9) < in_gap_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    send_word <= w;
    link_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // Drop valid and hold off until every predicted result has been delivered
  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Force the link idle, drain, then let the pipeline settle
  task automatic drain_link();
    link_event(MODE_TIMEOUT, 16'($urandom), 8'($urandom));
    wait_results();
    repeat (4) @(negedge clk);
  endtask

  // Write all three registers on back-to-back cycles, write enable held high
  task automatic apply_settings(input logic [7:0] a, input logic [7:0] n, input logic [7:0] l);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACK;
    cfg_data  <= a;
    @(negedge clk);
    cfg_index <= REG_NAK;
    cfg_data  <= n;
    @(negedge clk);
    cfg_index <= REG_LIMIT;
    cfg_data  <= l;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ack_set = a;
    nak_set = n;
  endtask

  // Reply byte aimed at ack, at nak, near either, or anywhere
  function automatic logic [7:0] reply_byte();
    case ($urandom_range(0, 4))
      0: return ack_set;
      1: return nak_set;
      2: return ack_set + 8'($urandom_range(0, 6)) - 8'd3;
      3: return nak_set + 8'($urandom_range(0, 6)) - 8'd3;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed send or receive exchanges with random content,
  // plus bad checksums, timeouts and plain noise
  task automatic random_transaction();
    logic [7:0] hi, lo, chk, rb;
    int         pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      link_event(MODE_SEND, 16'($urandom), 8'($urandom));
      for (int i = 0; i < $urandom_range(1, 4); i++) begin
        rb = reply_byte();
        link_event(MODE_BYTE, 16'($urandom), rb);
        if (rb == ack_set) break;
      end
      if ($urandom_range(0, 4) == 0) link_event(MODE_TIMEOUT, 16'($urandom), 8'($urandom));
    end else if (pick < 8) begin
      link_event(MODE_RECV, 16'($urandom), 8'($urandom));
      for (int i = 0; i < $urandom_range(1, 3); i++) begin
        hi  = 8'($urandom);
        lo  = 8'($urandom);
        chk = hi + lo;
        // corrupt about a third of the checksums
        if ($urandom_range(0, 2) == 0) chk = chk ^ 8'($urandom_range(1, 255));
        link_event(MODE_BYTE, 16'($urandom), hi);
        if ($urandom_range(0, 11) == 0) begin
          link_event(MODE_TIMEOUT, 16'($urandom), 8'($urandom));
          break;
        end
        link_event(MODE_BYTE, 16'($urandom), lo);
        link_event(MODE_BYTE, 16'($urandom), chk);
        if (chk == hi + lo) break;
      end
    end else if (pick == 8) begin
      link_event(2'($urandom), 16'($urandom), 8'($urandom));
    end else begin
      link_event(MODE_TIMEOUT, 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int         target;
    int         half;
    logic [7:0] a, n, l;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset register values: ack 6, nak 21, limit 3.
    // Stray byte and timeout while idle: both dropped.
    link_event(MODE_BYTE, 16'hffff, 8'hff);
    link_event(MODE_TIMEOUT, 16'h0000, 8'h00);
    // All-ones word: checksum wraps to 0xfe. Busy commands are dropped.
    link_event(MODE_SEND, 16'hffff, 8'h00);
    link_event(MODE_RECV, 16'h0000, 8'hff);
    link_event(MODE_SEND, 16'h5a5a, 8'h00);
    // Nak, far byte, nak again: two resends then a data error
    link_event(MODE_BYTE, 16'h0000, 8'd21);
    link_event(MODE_BYTE, 16'h0000, 8'hff);
    link_event(MODE_BYTE, 16'h0000, 8'd21);
    // Zero word acknowledged at once
    link_event(MODE_SEND, 16'h0000, 8'h00);
    link_event(MODE_BYTE, 16'hffff, 8'd6);
    // Timeout while awaiting the reply
    link_event(MODE_SEND, 16'h1234, 8'h00);
    link_event(MODE_TIMEOUT, 16'h0000, 8'h00);
    // Good frame received
    link_event(MODE_RECV, 16'h0000, 8'h00);
    link_event(MODE_BYTE, 16'h0000, 8'h12);
    link_event(MODE_BYTE, 16'h0000, 8'h34);
    link_event(MODE_BYTE, 16'h0000, 8'h46);
    // Bad checksum answered with nak, then an all-zero frame accepted
    link_event(MODE_RECV, 16'h0000, 8'h00);
    link_event(MODE_BYTE, 16'h0000, 8'hab);
    link_event(MODE_BYTE, 16'h0000, 8'hcd);
    link_event(MODE_BYTE, 16'h0000, 8'h00);
    link_event(MODE_BYTE, 16'h0000, 8'h00);
    link_event(MODE_BYTE, 16'h0000, 8'h00);
    link_event(MODE_BYTE, 16'h0000, 8'h00);
    drain_link();

    // Zero limit acts as one attempt; receive gives nak then data error
    apply_settings(8'd0, 8'd255, 8'd0);
    link_event(MODE_RECV, 16'h0000, 8'h00);
    link_event(MODE_BYTE, 16'h0000, 8'hff);
    link_event(MODE_BYTE, 16'h0000, 8'h01);
    link_event(MODE_BYTE, 16'h0000, 8'h55);
    link_event(MODE_SEND, 16'h8001, 8'h00);
    link_event(MODE_BYTE, 16'h0000, 8'hf0);
    drain_link();

    // Random part: one register setting per phase, quiet between phases
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin a = 8'd200; n = 8'd100; l = 8'd2;   in_gap_rate = 0; out_stall_rate = 0; end
        1: begin a = 8'd255; n = 8'd0;   l = 8'd1;   in_gap_rate = 3; out_stall_rate = 3; end
        // ack equal to nak: no reply is ever accepted
        2: begin a = 8'd128; n = 8'd128; l = 8'd255; in_gap_rate = 5; out_stall_rate = 6; end
        3: begin a = 8'd0;   n = 8'd255; l = 8'd4;   in_gap_rate = 2; out_stall_rate = 8; end
        4: begin
          a = 8'($urandom);
          n = 8'($urandom);
          l = 8'($urandom_range(1, 6));
          in_gap_rate    = 4;
          out_stall_rate = 4;
        end
        default: begin a = ACK_RESET; n = NAK_RESET; l = LIMIT_RESET; end
      endcase
      calm = (p == 5);
      apply_settings(a, n, l);
      half   = sent_items + 11;
      target = sent_items + 22;
      while (sent_items < half) random_transaction();
      // Hold the sender until the output side has caught up completely
      if (p == 2) wait_results();
      while (sent_items < target) random_transaction();
      drain_link();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
